// ===== rtl/hkvs_pkg.sv =====
// ----------------------------------------------------------------------------
// hkvs_pkg
// Shared constants and types for the hashed key-value store.
// ----------------------------------------------------------------------------
package hkvs_pkg;

    localparam int BUCKETS     = 16;
    localparam int WAYS        = 4;
    localparam int KEY_WIDTH   = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;

    // operation codes
    localparam logic [1:0] MODE_GET    = 2'd0;
    localparam logic [1:0] MODE_PUT    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // one classified request between front and back
    typedef struct packed {
        logic [1:0]             mode;
        logic [KEY_WIDTH-1:0]   key;
        logic [VALUE_WIDTH-1:0] value;
        logic [BUCKET_BITS-1:0] bucket;
    } t_req;

    // one result word
    typedef struct packed {
        logic        hit;
        logic [31:0] value;
        logic [1:0]  status;
    } t_res;

    // bucket index: remainder of the key by BUCKETS
    function automatic logic [BUCKET_BITS-1:0] bucket_of(input logic [KEY_WIDTH-1:0] k);
        logic [KEY_WIDTH-1:0] r;
        r = k % KEY_WIDTH'(BUCKETS);
        return r[BUCKET_BITS-1:0];
    endfunction

endpackage

// ===== rtl/hash_key_value_store_core.sv =====
// ----------------------------------------------------------------------------
// hash_key_value_store_core
// Hashed key-value store, bucket = key mod BUCKETS, WAYS entries per bucket.
// ----------------------------------------------------------------------------
// A request passes through the back end in order: a read of the bucket's
// ways from the per-way RAMs, a compare and write-back, and the result
// register. The back end takes a new word only once the previous result
// has been popped. A two-word input queue takes new words while the back
// end works. Valid marks are flip-flops cleared at reset, so no clearing
// pass is needed.
module hash_key_value_store_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_lookup_key,
    input  logic [31:0] i_value_in,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_hit,
    output logic [31:0] o_value_out,
    output logic [1:0]  o_status
);
    import hkvs_pkg::*;

    logic w_req_valid, w_req_take;
    t_req w_req;

    // front: accept and classify
    hkvs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_mode(i_mode), .i_lookup_key(i_lookup_key), .i_value_in(i_value_in),
        .o_req_valid(w_req_valid), .o_req(w_req), .i_req_take(w_req_take)
    );

    // back: bucket lookup and update
    hkvs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(w_req_valid),
        .i_req(w_req), .o_req_take(w_req_take), .o_empty(o_empty),
        .i_pop(i_pop), .o_hit(o_hit), .o_value_out(o_value_out),
        .o_status(o_status)
    );

endmodule

// ===== rtl/hkvs_ram.sv =====
// ----------------------------------------------------------------------------
// hkvs_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module hkvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/hkvs_front.sv =====
// ----------------------------------------------------------------------------
// hkvs_front
// Accepts requests, masks fields, computes the bucket, feeds a two-deep queue.
// ----------------------------------------------------------------------------
module hkvs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_mode,
    input  logic [31:0]   i_lookup_key,
    input  logic [31:0]   i_value_in,
    output logic          o_req_valid,
    output hkvs_pkg::t_req o_req,
    input  logic          i_req_take
);
    import hkvs_pkg::*;

    t_req       r_q [2];
    logic [1:0] r_cnt, n_cnt;
    logic       r_rd, r_wr;
    t_req       w_new;
    logic       w_acc;

    // classify incoming word
    always_comb begin
        w_new.mode   = i_mode;
        w_new.key    = KEY_WIDTH'(i_lookup_key);
        w_new.value  = VALUE_WIDTH'(i_value_in);
        w_new.bucket = bucket_of(w_new.key);
    end

    assign o_full      = r_cnt[1];
    assign w_acc       = i_push && !o_full;
    assign o_req_valid = r_cnt != 2'd0;
    assign o_req       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + 2'(w_acc) - 2'(i_req_take && o_req_valid);
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_acc) r_wr <= !r_wr;
            if (i_req_take && o_req_valid) r_rd <= !r_rd;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_acc) r_q[r_wr] <= w_new;
    end

endmodule

// ===== rtl/hkvs_back.sv =====
// ----------------------------------------------------------------------------
// hkvs_back
// Reads a bucket, compares all ways, writes back and produces the result.
// ----------------------------------------------------------------------------
module hkvs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  hkvs_pkg::t_req i_req,
    output logic           o_req_take,
    output logic           o_empty,
    input  logic           i_pop,
    output logic           o_hit,
    output logic [31:0]    o_value_out,
    output logic [1:0]     o_status
);
    import hkvs_pkg::*;

    localparam int KV_W = KEY_WIDTH + VALUE_WIDTH;

    // valid marks in flip-flops, keys and values in one ram per way
    logic [WAYS-1:0] r_valid [BUCKETS];
    logic            r_busy;
    t_req            r_req;
    logic            r_out_v;
    t_res            r_out;

    logic [KV_W-1:0] w_rd [WAYS];
    logic [WAYS-1:0] w_we;
    logic [KV_W-1:0] w_wd;
    logic [WAYS-1:0] w_vb, w_match, w_free;
    logic            w_any, w_anyfree;
    logic [WAY_BITS-1:0] w_mw, w_fw;
    logic [VALUE_WIDTH-1:0] w_mval;
    t_res            w_res;

    // one request at a time: read cycle then compare cycle, and none while a result waits to be popped
    assign o_req_take = i_req_valid && !r_busy && !r_out_v;

    for (genvar g = 0; g < WAYS; g++) begin : g_way
        hkvs_ram #(.WIDTH(KV_W), .DEPTH(BUCKETS)) u_ram (
            .i_clk  (i_clk),
            .i_we   (w_we[g]),
            .i_waddr(r_req.bucket),
            .i_wdata(w_wd),
            .i_raddr(i_req.bucket),
            .o_rdata(w_rd[g])
        );
    end

    // way compare and priority pick
    always_comb begin
        w_vb      = r_valid[r_req.bucket];
        w_any     = 1'b0;
        w_anyfree = 1'b0;
        w_mw      = '0;
        w_fw      = '0;
        w_mval    = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            w_match[w] = w_vb[w] && (w_rd[w][KV_W-1:VALUE_WIDTH] == r_req.key);
            w_free[w]  = !w_vb[w];
            if (w_free[w]) begin
                w_anyfree = 1'b1;
                w_fw      = WAY_BITS'(w);
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (w_match[w]) begin
                w_any  = 1'b1;
                w_mw   = WAY_BITS'(w);
                w_mval = w_rd[w][VALUE_WIDTH-1:0];
            end
        end
    end

    // result and write-back decision
    always_comb begin
        w_res = '0;
        w_we  = '0;
        w_wd  = {r_req.key, r_req.value};
        unique case (r_req.mode)
            MODE_GET: begin
                if (w_any) begin
                    w_res.hit   = 1'b1;
                    w_res.value = 32'(w_mval);
                end else begin
                    w_res.status = ST_NOTFOUND;
                end
            end
            MODE_PUT: begin
                if (w_any) begin
                    w_res.hit = 1'b1;
                    w_we[w_mw] = r_busy;
                end else if (w_anyfree) begin
                    w_we[w_fw] = r_busy;
                end else begin
                    w_res.status = ST_FULL;
                end
            end
            MODE_REMOVE: begin
                if (w_any) w_res.hit = 1'b1;
                else       w_res.status = ST_NOTFOUND;
            end
            default: w_res = '0;
        endcase
    end

    // control and valid marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_out_v <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) r_valid[b] <= '0;
        end else begin
            if (o_req_take) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy  <= 1'b0;
                r_out_v <= 1'b1;
                if (r_req.mode == MODE_PUT && !w_any && w_anyfree)
                    r_valid[r_req.bucket][w_fw] <= 1'b1;
                if (r_req.mode == MODE_REMOVE && w_any)
                    r_valid[r_req.bucket][w_mw] <= 1'b0;
            end
            if (r_out_v && i_pop) r_out_v <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (o_req_take) r_req <= i_req;
        if (r_busy) r_out <= w_res;
    end

    assign o_empty     = !r_out_v;
    assign o_hit       = r_out.hit;
    assign o_value_out = r_out.value;
    assign o_status    = r_out.status;

endmodule

// ===== rtl/hkvs_checker.sv =====
// ----------------------------------------------------------------------------
// hkvs_checker
// Port-level checks on the key-value store results.
// ----------------------------------------------------------------------------
module hkvs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic        o_hit,
    input logic [31:0] o_value_out,
    input logic [1:0]  o_status
);
    import hkvs_pkg::*;

    // a hit always reports ok
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_hit) |-> o_status == ST_OK)
        else $error("hit with non-ok status");

    // a miss never carries a value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_hit) |-> o_value_out == 32'd0)
        else $error("value on miss");

    // status code is never three
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_status != 2'd3)
        else $error("bad status");

    // an unpopped word stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> !o_empty && $stable(o_status))
        else $error("result dropped");

endmodule

bind hash_key_value_store_core hkvs_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_empty(o_empty), .i_pop(i_pop),
    .o_hit(o_hit), .o_value_out(o_value_out), .o_status(o_status)
);

// ===== test/hash_key_value_store_core_test.sv =====
// ----------------------------------------------------------------------------
// hash_key_value_store_core_test
// Self-checking bench for the hashed key-value store: a directed table of
// requests followed by random traffic aimed at a few buckets, each result
// word compared against its typed-in result or a behavioural model of the store.
// ----------------------------------------------------------------------------
module hash_key_value_store_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hkvs_pkg::*;

    localparam int N_RANDOM   = 400;
    localparam int IDLE_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [1:0]  i_mode = MODE_GET;
    logic [31:0] i_lookup_key = '0;
    logic [31:0] i_value_in = '0;
    logic        i_pop = 1'b0;
    logic        o_full, o_empty, o_hit;
    logic [31:0] o_value_out;
    logic [1:0]  o_status;

    hash_key_value_store_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // model of the store contents
    logic                   shadow_valid [BUCKETS*WAYS];
    logic [KEY_WIDTH-1:0]   shadow_key   [BUCKETS*WAYS];
    logic [VALUE_WIDTH-1:0] shadow_value [BUCKETS*WAYS];

    t_res pending_results [$];
    int   mismatch_count = 0;
    int   words_checked = 0;
    int   idle_cycles = 0;
    int   n_get = 0, n_put = 0, n_remove = 0, n_full = 0;

    // directed requests; known_ok marks rows with a result typed in
    typedef struct {
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] value;
        logic        known_ok;
        t_res        res;
    } t_row;

    // apply one request to the model and return its result word
    function automatic t_res store_access(logic [1:0] mode, logic [31:0] key,
                                          logic [31:0] value);
        t_res r;
        int   base, found, slot;
        r = '0;
        base = int'(key % BUCKETS) * WAYS;
        found = -1;
        slot = -1;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (shadow_valid[base+w] && shadow_key[base+w] == key) found = w;
            if (!shadow_valid[base+w]) slot = w;
        end
        case (mode)
            MODE_GET: begin
                n_get++;
                if (found >= 0) begin
                    r.hit = 1'b1;
                    r.value = shadow_value[base+found];
                end else r.status = ST_NOTFOUND;
            end
            MODE_PUT: begin
                n_put++;
                if (found >= 0) begin
                    shadow_value[base+found] = value;
                    r.hit = 1'b1;
                end else if (slot >= 0) begin
                    shadow_valid[base+slot] = 1'b1;
                    shadow_key[base+slot] = key;
                    shadow_value[base+slot] = value;
                end else begin
                    r.status = ST_FULL;
                    n_full++;
                end
            end
            MODE_REMOVE: begin
                n_remove++;
                if (found >= 0) begin
                    shadow_valid[base+found] = 1'b0;
                    r.hit = 1'b1;
                end else r.status = ST_NOTFOUND;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // drive one word and wait until it is taken
    task automatic push_word(t_row row);
        t_res predicted;
        i_push <= 1'b1;
        i_mode <= row.mode;
        i_lookup_key <= row.key;
        i_value_in <= row.value;
        do @(posedge i_clk); while (o_full);
        predicted = store_access(row.mode, row.key, row.value);
        if (row.known_ok && predicted != row.res)
            $display("table row disagrees with model: key %h", row.key);
        pending_results.push_back(row.known_ok ? row.res : predicted);
        @(negedge i_clk);
    endtask

    // random gap, mostly short, sometimes long
    task automatic sender_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n > 0) begin
            i_push <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    // random key, mostly within buckets 0 to 3, so they fill up and collide
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(0, 9))
            0: k = $urandom();
            1: k = {$urandom_range(0, 1) ? 28'hfffffff : 28'h0, 4'($urandom_range(0, 3))};
            default: k = {26'($urandom_range(0, 1) ? 26'h3ffffff : 26'h0) ^
                          26'($urandom_range(0, 5)), 2'b00, 4'($urandom_range(0, 3))};
        endcase
        return k;
    endfunction

    // receiver: random stalls, compares each popped word
    always @(negedge i_clk) begin
        if (!i_rst_n) i_pop <= 1'b0;
        else if ($urandom_range(0, 19) == 0) i_pop <= 1'b0;
        else if ($urandom_range(0, 3) == 0) i_pop <= ($urandom_range(0, 1) == 1);
        else i_pop <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) idle_cycles = 0;
            else idle_cycles++;
            if (i_pop && !o_empty) begin
                words_checked++;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: hit %b value %h status %0d",
                                 o_hit, o_value_out, o_status);
                end else begin
                    want = pending_results.pop_front();
                    if (o_hit !== want.hit || o_value_out !== want.value ||
                        o_status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"word %0d: expected hit %b value %h status %0d,",
                                      " got hit %b value %h status %0d"},
                                     words_checked, want.hit, want.value, want.status,
                                     o_hit, o_value_out, o_status);
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_row rows [$];
        t_row row;
        int   op;
        for (int e = 0; e < BUCKETS*WAYS; e++) begin
            shadow_valid[e] = 1'b0;
            shadow_key[e] = '0;
            shadow_value[e] = '0;
        end
        // directed: misses on empty store, extremes, fill bucket 3, full, remove
        rows = '{
            '{MODE_GET,    32'h0000_0000, 32'h0,         1'b1, '{1'b0, 32'h0, ST_NOTFOUND}},
            '{MODE_REMOVE, 32'hffff_ffff, 32'h0,         1'b1, '{1'b0, 32'h0, ST_NOTFOUND}},
            '{2'd3,        32'h1234_5678, 32'hffff_ffff, 1'b1, '{1'b0, 32'h0, ST_OK}},
            '{MODE_PUT,    32'h0000_0000, 32'hffff_ffff, 1'b1, '{1'b0, 32'h0, ST_OK}},
            '{MODE_GET,    32'h0000_0000, 32'h0,         1'b1, '{1'b1, 32'hffff_ffff, ST_OK}},
            '{MODE_PUT,    32'hffff_ffff, 32'h0,         1'b1, '{1'b0, 32'h0, ST_OK}},
            '{MODE_GET,    32'hffff_ffff, 32'h5,         1'b1, '{1'b1, 32'h0, ST_OK}},
            '{MODE_PUT,    32'h0000_0000, 32'haaaa_5555, 1'b1, '{1'b1, 32'h0, ST_OK}},
            '{MODE_PUT,    32'h0000_0003, 32'h1,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_PUT,    32'h0000_0013, 32'h2,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_PUT,    32'hffff_fff3, 32'h3,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_PUT,    32'h8000_0003, 32'h4,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_PUT,    32'h0000_0023, 32'h5,         1'b1, '{1'b0, 32'h0, ST_FULL}},
            '{MODE_PUT,    32'h0000_0013, 32'h6,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_REMOVE, 32'h0000_0013, 32'h0,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_GET,    32'h0000_0013, 32'h0,         1'b1, '{1'b0, 32'h0, ST_NOTFOUND}},
            '{MODE_PUT,    32'h0000_0023, 32'h5555_aaaa, 1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_GET,    32'h0000_0023, 32'h0,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_GET,    32'h8000_0003, 32'h0,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_REMOVE, 32'h0000_0000, 32'h0,         1'b0, '{1'b0, 32'h0, ST_OK}},
            '{MODE_GET,    32'h0000_0000, 32'h0,         1'b1, '{1'b0, 32'h0, ST_NOTFOUND}}
        };
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[i]) begin
            push_word(rows[i]);
            sender_gap();
        end
        // hold off until the store has answered everything
        i_push <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge i_clk);
        // random traffic, mostly valid operations on crowded buckets
        for (int n = 0; n < N_RANDOM; n++) begin
            op = $urandom_range(0, 19);
            row.mode = (op < 8) ? MODE_PUT : (op < 14) ? MODE_GET :
                       (op < 19) ? MODE_REMOVE : 2'd3;
            row.key = pick_key();
            row.value = $urandom();
            row.known_ok = 1'b0;
            row.res = '0;
            push_word(row);
            sender_gap();
            if (n == N_RANDOM / 2) begin
                i_push <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge i_clk);
            end
        end
        i_push <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge i_clk);
        $display("covered %0d gets, %0d puts (%0d into full buckets), %0d removes",
                 n_get, n_put, n_full, n_remove);
        $display("%0d result words compared, %0d mismatches", words_checked, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
